// ===== hw/rtl/ctstr_pkg.sv =====
// ----------------------------------------------------------------------------
// ctstr_pkg
// shared types and constants of the can transmit slot tracker with rx ring
// ----------------------------------------------------------------------------
`default_nettype none

package ctstr_pkg;

  localparam logic [2:0] ACT_SEND   = 3'd0;
  localparam logic [2:0] ACT_TXDONE = 3'd1;
  localparam logic [2:0] ACT_TICK   = 3'd2;
  localparam logic [2:0] ACT_RECV   = 3'd3;
  localparam logic [2:0] ACT_POP    = 3'd4;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_BUSY  = 2'd1;
  localparam logic [1:0] STS_UNSUP = 2'd2;
  localparam logic [1:0] STS_EMPTY = 2'd3;

  localparam logic [7:0]  TEC_LIMIT = 8'd250;
  localparam logic [3:0]  MAX_DLC   = 4'd8;
  localparam logic [3:0]  ABORT_MAX = 4'd15;
  localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
  localparam int unsigned STD_SHIFT = 18;
  localparam int unsigned EXT_BITS  = 29;
  localparam int unsigned STD_BITS  = 11;
  localparam int unsigned BIT_EXT   = 31;
  localparam int unsigned BIT_RTR   = 30;
  localparam int unsigned BIT_ERR   = 29;

  typedef enum logic [2:0] {
    OP_SEND,
    OP_TXDONE,
    OP_TICK,
    OP_RECV,
    OP_POP,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TX_PUSH,
    BK_TICK_RD,
    BK_TICK_CMP,
    BK_POP_RD,
    BK_POLL,
    BK_RESULT
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic        send_bad;
    logic [31:0] id;
    logic [3:0]  dlc;
    logic [63:0] data;
    logic        loopback;
    logic [63:0] deadline;
    logic [63:0] now;
    logic        hw_full;
    logic        poll_hit;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] id;
    logic [3:0]  dlc;
    logic [63:0] data;
    logic [63:0] time_usec;
    logic        loopback;
    logic [3:0]  aborts;
    logic [4:0]  rx_len;
    logic [3:0]  tx_queued;
    logic [32:0] err_total;
  } result_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] id;
    logic [3:0]  dlc;
    logic [63:0] data;
  } slot_rec_t;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  dlc;
    logic [63:0] data;
    logic [63:0] time_usec;
    logic        loopback;
  } ring_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ctstr_ram.sv =====
// ----------------------------------------------------------------------------
// ctstr_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ctstr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ctstr_front.sv =====
// ----------------------------------------------------------------------------
// ctstr_front
// accepts words, decodes the action and prepares fields, two entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module ctstr_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [2:0]       action_i,
  input  wire logic [31:0]      frame_id_i,
  input  wire logic [3:0]       frame_dlc_i,
  input  wire logic [63:0]      frame_data_i,
  input  wire logic [2:0]       raw_flags_i,
  input  wire logic             loopback_req_i,
  input  wire logic [63:0]      deadline_usec_i,
  input  wire logic [63:0]      now_usec_i,
  input  wire logic             hw_buffer_full_i,
  input  wire logic             error_flagged_i,
  input  wire logic [7:0]       tx_error_count_i,
  output logic                  item_valid_o,
  output ctstr_pkg::item_t      item_o,
  input  wire logic             item_pop_i
);

  import ctstr_pkg::*;

  item_t      fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  item_t      dec;
  logic [31:0] rx_id;
  logic       push;

  always_comb begin
    rx_id = '0;
    if (raw_flags_i[0]) begin
      rx_id[EXT_BITS-1:0] = frame_id_i[EXT_BITS-1:0];
      rx_id[BIT_EXT]      = 1'b1;
    end else begin
      rx_id[STD_BITS-1:0] = frame_id_i[STD_SHIFT+STD_BITS-1:STD_SHIFT];
    end
    rx_id[BIT_RTR] = rx_id[BIT_RTR] | raw_flags_i[1];
    rx_id[BIT_ERR] = rx_id[BIT_ERR] | raw_flags_i[2];

    dec          = '0;
    dec.id       = frame_id_i;
    dec.dlc      = frame_dlc_i;
    dec.data     = frame_data_i;
    dec.loopback = loopback_req_i;
    dec.deadline = deadline_usec_i;
    dec.now      = now_usec_i;
    dec.hw_full  = hw_buffer_full_i;
    dec.send_bad = frame_id_i[BIT_ERR] || (frame_dlc_i > MAX_DLC);
    dec.poll_hit = error_flagged_i && (tx_error_count_i > TEC_LIMIT);
    case (action_i)
      ACT_SEND:   dec.op = OP_SEND;
      ACT_TXDONE: dec.op = OP_TXDONE;
      ACT_TICK:   dec.op = OP_TICK;
      ACT_RECV: begin
        dec.op = OP_RECV;
        dec.id = rx_id;
        // bytes past the length code are cleared
        for (int b = 0; b < 8; b++) begin
          if (4'(b) >= frame_dlc_i) begin
            dec.data[8*b +: 8] = 8'd0;
          end
        end
      end
      ACT_POP:    dec.op = OP_POP;
      default:    dec.op = OP_NONE;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (item_pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(item_pop_i);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ctstr_back.sv =====
// ----------------------------------------------------------------------------
// ctstr_back
// executes one queued item: slot table, order list, rx ring, result register
// ----------------------------------------------------------------------------
`default_nettype none

module ctstr_back #(
  parameter int unsigned TX_SLOTS = 8,
  parameter int unsigned RX_DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  input  ctstr_pkg::item_t      item_i,
  output logic                  item_pop_o,
  output logic                  out_valid_o,
  output ctstr_pkg::result_t    out_o,
  input  wire logic             out_ready_i
);

  import ctstr_pkg::*;

  localparam int unsigned SW  = (TX_SLOTS > 1) ? $clog2(TX_SLOTS) : 1;
  localparam int unsigned LW  = $clog2(TX_SLOTS + 1);
  localparam int unsigned RAW = $clog2(RX_DEPTH);
  localparam int unsigned RLW = $clog2(RX_DEPTH + 1);
  localparam logic [SW-1:0]  LAST_SLOT = SW'(TX_SLOTS - 1);
  localparam logic [RAW-1:0] LAST_POS  = RAW'(RX_DEPTH - 1);

  back_state_e      state_q, state_d;
  logic [SW-1:0]    idx_q, idx_d;
  logic [TX_SLOTS-1:0] pend_q, pend_d, lpbk_q, lpbk_d;
  logic [SW-1:0]    ord_q [TX_SLOTS];
  logic [SW-1:0]    ord_d [TX_SLOTS];
  logic [LW-1:0]    olen_q, olen_d;
  logic [RAW-1:0]   rin_q, rin_d, rout_q, rout_d;
  logic [RLW-1:0]   rlen_q, rlen_d;
  logic [31:0]      ovf_q, ovf_d, err_q, err_d;
  result_t          res_q, res_d, out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic             s_we;
  logic [SW-1:0]    s_waddr, s_raddr;
  slot_rec_t        s_wdata, s_rdata;
  logic             push_en;
  ring_rec_t        push_rec, r_rdata;

  logic             free_found;
  logic [SW-1:0]    free_slot;
  logic [SW-1:0]    head_slot;
  logic             rm_en, rm_hit;
  logic             err_inc;

  ctstr_ram #(.WIDTH($bits(slot_rec_t)), .DEPTH(TX_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  ctstr_ram #(.WIDTH($bits(ring_rec_t)), .DEPTH(RX_DEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i (rin_q),
    .wdata_i (push_rec),
    .raddr_i (rout_q),
    .rdata_o (r_rdata)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = TX_SLOTS - 1; i >= 0; i--) begin
      if (!pend_q[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  assign head_slot = ord_q[0];
  assign s_raddr   = (state_q == BK_IDLE) ? head_slot : idx_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    lpbk_d     = lpbk_q;
    ord_d      = ord_q;
    olen_d     = olen_q;
    rin_d      = rin_q;
    rout_d     = rout_q;
    rlen_d     = rlen_q;
    ovf_d      = ovf_q;
    err_d      = err_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    item_pop_o = 1'b0;
    s_we       = 1'b0;
    s_waddr    = free_slot;
    s_wdata    = '{deadline: item_i.deadline, id: item_i.id, dlc: item_i.dlc,
                   data: item_i.data};
    push_en    = 1'b0;
    push_rec   = '{id: item_i.id, dlc: item_i.dlc, data: item_i.data,
                   time_usec: item_i.now, loopback: 1'b0};
    rm_en      = 1'b0;
    rm_hit     = 1'b0;
    err_inc    = 1'b0;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          res_d        = '0;
          res_d.status = STS_BUSY;
          idx_d        = '0;
          state_d      = BK_RESULT;
          case (item_i.op)
            OP_SEND: begin
              if (item_i.send_bad) begin
                res_d.status = STS_UNSUP;
              end else if (olen_q < LW'(TX_SLOTS) && !item_i.hw_full && free_found) begin
                s_we              = 1'b1;
                pend_d[free_slot] = 1'b1;
                lpbk_d[free_slot] = item_i.loopback;
                for (int k = 0; k < TX_SLOTS; k++) begin
                  if (LW'(k) == olen_q) begin
                    ord_d[k] = free_slot;
                  end
                end
                olen_d       = olen_q + 1'b1;
                res_d.status = STS_OK;
              end
            end
            OP_TXDONE: begin
              if (olen_q != '0) begin
                for (int k = 0; k < TX_SLOTS - 1; k++) begin
                  ord_d[k] = ord_q[k+1];
                end
                olen_d       = olen_q - 1'b1;
                res_d.status = STS_OK;
                if (pend_q[head_slot]) begin
                  pend_d[head_slot] = 1'b0;
                  if (lpbk_q[head_slot]) begin
                    state_d = BK_TX_PUSH;
                  end else if (item_i.poll_hit) begin
                    state_d = BK_POLL;
                  end
                end
              end
            end
            OP_TICK: state_d = BK_TICK_RD;
            OP_RECV: begin
              push_en      = 1'b1;
              res_d.status = STS_OK;
              if (item_i.poll_hit) begin
                state_d = BK_POLL;
              end
            end
            OP_POP: begin
              if (rlen_q == '0) begin
                res_d.status = STS_EMPTY;
              end else begin
                state_d = BK_POP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      BK_TX_PUSH: begin
        push_en  = 1'b1;
        push_rec = '{id: s_rdata.id, dlc: s_rdata.dlc, data: s_rdata.data,
                     time_usec: item_i.now, loopback: 1'b1};
        state_d  = item_i.poll_hit ? BK_POLL : BK_RESULT;
      end
      BK_TICK_RD: state_d = BK_TICK_CMP;
      BK_TICK_CMP: begin
        if (pend_q[idx_q] && (s_rdata.deadline < item_i.now)) begin
          pend_d[idx_q] = 1'b0;
          err_inc       = 1'b1;
          rm_en         = 1'b1;
          res_d.status  = STS_OK;
          if (res_q.aborts != ABORT_MAX) begin
            res_d.aborts = res_q.aborts + 1'b1;
          end
        end
        if (idx_q == LAST_SLOT) begin
          state_d = BK_RESULT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = BK_TICK_RD;
        end
      end
      BK_POP_RD: begin
        res_d.status    = STS_OK;
        res_d.id        = r_rdata.id;
        res_d.dlc       = r_rdata.dlc;
        res_d.data      = r_rdata.data;
        res_d.time_usec = r_rdata.time_usec;
        res_d.loopback  = r_rdata.loopback;
        rout_d          = (rout_q == LAST_POS) ? '0 : rout_q + 1'b1;
        rlen_d          = rlen_q - 1'b1;
        state_d         = BK_RESULT;
      end
      BK_POLL: begin
        if (pend_q[idx_q]) begin
          pend_d[idx_q] = 1'b0;
          err_inc       = 1'b1;
        end
        if (idx_q == LAST_SLOT) begin
          state_d = BK_RESULT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      BK_RESULT: begin
        if (!out_vld_q || out_ready_i) begin
          out_d           = res_q;
          out_d.rx_len    = 5'(rlen_q);
          out_d.tx_queued = 4'(olen_q);
          out_d.err_total = {1'b0, err_q} + {1'b0, ovf_q};
          out_vld_d       = 1'b1;
          item_pop_o      = 1'b1;
          state_d         = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase

    // drop the first order entry that names the aborted slot
    if (rm_en) begin
      for (int k = 0; k < TX_SLOTS; k++) begin
        if (!rm_hit && LW'(k) < olen_q && ord_q[k] == idx_q) begin
          rm_hit = 1'b1;
        end
        if (rm_hit && k < TX_SLOTS - 1) begin
          ord_d[k] = ord_q[k+1];
        end
      end
      if (rm_hit) begin
        olen_d = olen_q - 1'b1;
      end
    end

    if (push_en) begin
      rin_d = (rin_q == LAST_POS) ? '0 : rin_q + 1'b1;
      if (rlen_q == RLW'(RX_DEPTH)) begin
        // ring full: oldest frame is overwritten
        rout_d = (rout_q == LAST_POS) ? '0 : rout_q + 1'b1;
        if (ovf_q != SAT32) begin
          ovf_d = ovf_q + 1'b1;
        end
      end else begin
        rlen_d = rlen_q + 1'b1;
      end
    end

    if (err_inc && err_q != SAT32) begin
      err_d = err_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
    ord_q <= ord_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      idx_q     <= '0;
      pend_q    <= '0;
      lpbk_q    <= '0;
      olen_q    <= '0;
      rin_q     <= '0;
      rout_q    <= '0;
      rlen_q    <= '0;
      ovf_q     <= '0;
      err_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      lpbk_q    <= lpbk_d;
      olen_q    <= olen_d;
      rin_q     <= rin_d;
      rout_q    <= rout_d;
      rlen_q    <= rlen_d;
      ovf_q     <= ovf_d;
      err_q     <= err_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/can_tx_slot_tracker_rx_ring.sv =====
// ----------------------------------------------------------------------------
// can_tx_slot_tracker_rx_ring
// transmit slot tracker and receive frame ring for one can controller
// ----------------------------------------------------------------------------
// one command word in on the slave stream (action in tuser), one result word
// out on the master stream for every command. the front decodes commands into
// a two entry queue, the back executes them one at a time against the slot
// table, the transmit order list and the receive ring, then parks the result
// in an output register, so a stalled master side still lets two more words
// in. each word passes through the idle and result states of the back; pop
// adds a ring read state and transmit done of a loopback frame a push state.
// tick reads and compares each slot in turn, set by the one read port of the
// slot ram; an error poll after transmit done or receive visits every slot.
// the next word starts in the back the cycle after its result is registered.
// reset clears all slots, the order list, the ring pointers and counters;
// ram contents are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module can_tx_slot_tracker_rx_ring #(
  parameter int unsigned TX_SLOTS = 8,
  parameter int unsigned RX_DEPTH = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // frame_id, frame_dlc, frame_data, raw_flags, loopback_req, deadline_usec,
  // now_usec, hw_buffer_full, error_flagged, tx_error_count, zero fill
  input  wire logic [247:0] s_axis_tdata_i,
  // action
  input  wire logic [2:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // status, out_frame_id, out_dlc, out_data, out_time_usec, out_loopback,
  // abort_count, rx_length, tx_queued, error_total, zero fill
  output logic [215:0]      m_axis_tdata_o
);

  import ctstr_pkg::*;

  logic    item_valid, item_pop;
  item_t   item;
  result_t res;

  ctstr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .action_i         (s_axis_tuser_i),
    .frame_id_i       (s_axis_tdata_i[31:0]),
    .frame_dlc_i      (s_axis_tdata_i[35:32]),
    .frame_data_i     (s_axis_tdata_i[99:36]),
    .raw_flags_i      (s_axis_tdata_i[102:100]),
    .loopback_req_i   (s_axis_tdata_i[103]),
    .deadline_usec_i  (s_axis_tdata_i[167:104]),
    .now_usec_i       (s_axis_tdata_i[231:168]),
    .hw_buffer_full_i (s_axis_tdata_i[232]),
    .error_flagged_i  (s_axis_tdata_i[233]),
    .tx_error_count_i (s_axis_tdata_i[241:234]),
    .item_valid_o     (item_valid),
    .item_o           (item),
    .item_pop_i       (item_pop)
  );

  ctstr_back #(.TX_SLOTS(TX_SLOTS), .RX_DEPTH(RX_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_o        (res),
    .out_ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {3'd0, res.err_total, res.tx_queued, res.rx_len, res.aborts,
                           res.loopback, res.time_usec, res.data, res.dlc, res.id,
                           res.status};

endmodule

`default_nettype wire

// ===== hw/rtl/ctstr_checker.sv =====
// ----------------------------------------------------------------------------
// ctstr_checker
// port level checks on the result stream of the slot tracker
// ----------------------------------------------------------------------------
`default_nettype none

module ctstr_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [215:0] m_axis_tdata_o
);

  import ctstr_pkg::*;

  logic [1:0] status;
  logic [3:0] aborts;
  logic [4:0] rx_len;
  logic       loopback;

  assign status   = m_axis_tdata_o[1:0];
  assign loopback = m_axis_tdata_o[166];
  assign aborts   = m_axis_tdata_o[170:167];
  assign rx_len   = m_axis_tdata_o[175:171];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status == STS_EMPTY |-> rx_len == 5'd0)
    else $error("empty status with frames in ring");

  a_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && aborts != 4'd0 |-> status == STS_OK)
    else $error("aborts reported without ok status");

  a_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && loopback |-> status == STS_OK && rx_len != 5'd31)
    else $error("loopback frame without ok status");

endmodule

bind can_tx_slot_tracker_rx_ring ctstr_checker u_ctstr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
